FILE: rtl/core/imd_pwm_condition_decoder_core_defines.svh
// ----------------------------------------------------------------------------
// IMD PWM condition decoder assertion macros
// Shared concurrent assertion forms for the decoder checkers.
// ----------------------------------------------------------------------------
`ifndef IMD_PWM_CONDITION_DECODER_CORE_DEFINES_SVH
`define IMD_PWM_CONDITION_DECODER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define IMD_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("imd_pwm_cd: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define IMD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("imd_pwm_cd: next-cycle check failed");

`endif

FILE: rtl/core/imd_pwm_cd_pkg.sv
// ----------------------------------------------------------------------------
// IMD PWM condition decoder package
// Beat types, condition codes and constants shared by the decoder pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package imd_pwm_cd_pkg;

	typedef enum logic [2:0] {
		COND_SHORT      = 3'd0,
		COND_NORMAL     = 3'd1,
		COND_UNDERVOLT  = 3'd2,
		COND_SST        = 3'd3,
		COND_DEV_ERR    = 3'd4,
		COND_GND_FAULT  = 3'd5,
		COND_INVALID    = 3'd6
	} cond_t;

	typedef enum logic [1:0] {
		SST_NONE = 2'd0,
		SST_PASS = 2'd1,
		SST_BAD  = 2'd2
	} sst_t;

	// How the final stage forms the resistance
	typedef enum logic [1:0] {
		RES_ZERO = 2'd0,
		RES_SAT  = 2'd1,
		RES_CALC = 2'd2
	} res_mode_t;

	typedef struct packed {
		logic [15:0] frequency_centihz;
		logic [13:0] duty_centipercent;
		logic        pwm_timed_out;
	} in_beat_t;

	typedef struct packed {
		logic [2:0]  condition_code;
		logic        duty_valid;
		logic [15:0] insulation_kohms;
		logic [1:0]  start_status;
	} out_beat_t;

	typedef struct packed {
		cond_t     cond;
		logic      duty_valid;
		sst_t      sst;
		res_mode_t res_mode;
	} ctrl_t;

	typedef struct packed {
		ctrl_t       ctrl;
		logic [1:0]  step;
		logic [13:0] divisor;
		logic [13:0] rem;
		logic [15:0] quo;
	} div_state_t;

	localparam int unsigned NUM_WINDOWS       = 6;
	localparam logic [15:0] WINDOW_STEP       = 16'd1000;
	localparam logic [8:0]  TOL_RESET         = 9'd200;

	// Divider stages, four quotient bits each; matches the range of step
	localparam int unsigned NUM_DIV_STAGES    = 4;

	localparam logic [13:0] DUTY_LO           = 14'd500;
	localparam logic [13:0] DUTY_HI           = 14'd9500;
	localparam logic [13:0] SST_PASS_HI       = 14'd1000;
	localparam logic [13:0] SST_BAD_LO        = 14'd9000;
	localparam logic [13:0] FAULT_LO          = 14'd4750;
	localparam logic [13:0] FAULT_HI          = 14'd5250;
	// Above this duty the quotient fits 16 bits and stays under the clamp point
	localparam logic [13:0] DUTY_SAT_MAX      = 14'd710;

	// 10800000 = 0xA4CB80: the top byte seeds the remainder, the low 16 bits
	// feed the divider four bits per stage.
	localparam logic [13:0]      REM_SEED     = 14'd164;
	localparam logic [3:0][3:0]  RES_NUM_NIB  = 16'hCB80;

	localparam logic [15:0] RES_OFFSET        = 16'd1200;
	localparam logic [15:0] RES_MAX           = 16'd50000;
	localparam logic [15:0] RES_Q_CLAMP       = 16'd51200;

endpackage

FILE: rtl/core/imd_pwm_cd_classify.sv
// ----------------------------------------------------------------------------
// IMD PWM condition decoder classify stage
// Frequency window decode, duty window checks and divider setup.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module imd_pwm_cd_classify
	import imd_pwm_cd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic [8:0] tol,
	input  logic       up_valid,
	output logic       up_ready,
	input  in_beat_t   up_data,
	output logic       dn_valid,
	input  logic       dn_ready,
	output div_state_t dn_data
);

	logic [NUM_WINDOWS-1:0] hit;
	logic [15:0]            nom;
	logic [15:0]            lo;
	logic [15:0]            hi;
	logic [15:0]            tol_w;
	cond_t                  cond;
	ctrl_t                  ctrl;
	logic [13:0]            duty;
	logic                   duty_main;
	div_state_t             nxt;
	logic                   valid_s1;
	div_state_t             data_s1;

	assign tol_w = {7'd0, tol};
	assign duty  = up_data.duty_centipercent;

	always_comb begin
		hit = '0;
		nom = '0;
		lo  = '0;
		hi  = '0;
		for (int n = 0; n < NUM_WINDOWS; n++) begin
			nom = 16'(n) * WINDOW_STEP;
			lo  = (nom > tol_w) ? nom - tol_w : 16'd0;
			hi  = nom + tol_w;
			hit[n] = (up_data.frequency_centihz >= lo) && (up_data.frequency_centihz <= hi);
		end
	end

	// Lowest window wins where windows overlap
	always_comb begin
		if (up_data.pwm_timed_out) begin
			cond = COND_SHORT;
		end else if (hit[0]) begin
			cond = COND_SHORT;
		end else if (hit[1]) begin
			cond = COND_NORMAL;
		end else if (hit[2]) begin
			cond = COND_UNDERVOLT;
		end else if (hit[3]) begin
			cond = COND_SST;
		end else if (hit[4]) begin
			cond = COND_DEV_ERR;
		end else if (hit[5]) begin
			cond = COND_GND_FAULT;
		end else begin
			cond = COND_INVALID;
		end
	end

	assign duty_main = (duty >= DUTY_LO) && (duty <= DUTY_HI);

	always_comb begin
		ctrl.cond       = cond;
		ctrl.duty_valid = 1'b0;
		ctrl.sst        = SST_NONE;
		ctrl.res_mode   = RES_ZERO;
		case (cond)
			COND_SHORT: begin
				ctrl.duty_valid = 1'b1;
			end
			COND_NORMAL, COND_UNDERVOLT: begin
				ctrl.duty_valid = duty_main;
				if (duty_main) begin
					ctrl.res_mode = (duty <= DUTY_SAT_MAX) ? RES_SAT : RES_CALC;
				end
			end
			COND_SST: begin
				if ((duty >= DUTY_LO) && (duty <= SST_PASS_HI)) begin
					ctrl.duty_valid = 1'b1;
					ctrl.sst        = SST_PASS;
				end else if ((duty >= SST_BAD_LO) && (duty <= DUTY_HI)) begin
					ctrl.duty_valid = 1'b1;
					ctrl.sst        = SST_BAD;
				end
			end
			COND_DEV_ERR, COND_GND_FAULT: begin
				ctrl.duty_valid = (duty >= FAULT_LO) && (duty <= FAULT_HI);
			end
			default: begin
				ctrl.duty_valid = 1'b0;
			end
		endcase
	end

	always_comb begin
		nxt.ctrl    = ctrl;
		nxt.step    = 2'd0;
		nxt.divisor = duty - DUTY_LO;
		nxt.rem     = REM_SEED;
		nxt.quo     = '0;
	end

	assign up_ready = !valid_s1 || dn_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (up_ready) begin
			valid_s1 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			data_s1 <= nxt;
		end
	end

	assign dn_valid = valid_s1;
	assign dn_data  = data_s1;

endmodule

FILE: rtl/core/imd_pwm_cd_div_stage.sv
// ----------------------------------------------------------------------------
// IMD PWM condition decoder divider stage
// Four restoring-division steps of the resistance quotient, registered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module imd_pwm_cd_div_stage
	import imd_pwm_cd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       up_valid,
	output logic       up_ready,
	input  div_state_t up_data,
	output logic       dn_valid,
	input  logic       dn_ready,
	output div_state_t dn_data
);

	logic [3:0]  nib;
	logic [13:0] r;
	logic [14:0] t;
	logic [15:0] q;
	div_state_t  nxt;
	logic        valid_q;
	div_state_t  data_q;

	// Bring down one numerator bit per step, subtract when it fits
	always_comb begin
		nib = RES_NUM_NIB[~up_data.step];
		r   = up_data.rem;
		q   = up_data.quo;
		t   = '0;
		for (int i = 3; i >= 0; i--) begin
			t = {r, nib[i]};
			if (t >= {1'b0, up_data.divisor}) begin
				t = t - {1'b0, up_data.divisor};
				q = {q[14:0], 1'b1};
			end else begin
				q = {q[14:0], 1'b0};
			end
			r = t[13:0];
		end
		nxt      = up_data;
		nxt.rem  = r;
		nxt.quo  = q;
		nxt.step = up_data.step + 2'd1;
	end

	assign up_ready = !valid_q || dn_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (up_ready) begin
			valid_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			data_q <= nxt;
		end
	end

	assign dn_valid = valid_q;
	assign dn_data  = data_q;

endmodule

FILE: rtl/core/imd_pwm_cd_finish.sv
// ----------------------------------------------------------------------------
// IMD PWM condition decoder finish stage
// Offset and clamp of the resistance, result beat output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module imd_pwm_cd_finish
	import imd_pwm_cd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       up_valid,
	output logic       up_ready,
	input  div_state_t up_data,
	output logic       dn_valid,
	input  logic       dn_ready,
	output out_beat_t  dn_data
);

	logic [15:0] res;
	out_beat_t   nxt;
	logic        valid_s6;
	out_beat_t   data_s6;

	always_comb begin
		case (up_data.ctrl.res_mode)
			RES_SAT: begin
				res = RES_MAX;
			end
			RES_CALC: begin
				if (up_data.quo > RES_Q_CLAMP) begin
					res = RES_MAX;
				end else if (up_data.quo > RES_OFFSET) begin
					res = up_data.quo - RES_OFFSET;
				end else begin
					res = 16'd0;
				end
			end
			default: begin
				res = 16'd0;
			end
		endcase
		nxt.condition_code   = up_data.ctrl.cond;
		nxt.duty_valid       = up_data.ctrl.duty_valid;
		nxt.insulation_kohms = res;
		nxt.start_status     = up_data.ctrl.sst;
	end

	assign up_ready = !valid_s6 || dn_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s6 <= 1'b0;
		end else if (up_ready) begin
			valid_s6 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			data_s6 <= nxt;
		end
	end

	assign dn_valid = valid_s6;
	assign dn_data  = data_s6;

endmodule

FILE: rtl/core/imd_pwm_condition_decoder_core.sv
// ----------------------------------------------------------------------------
// IMD PWM condition decoder core
// Decodes one insulation-monitor PWM measurement per beat into a condition.
// ----------------------------------------------------------------------------
// Each input beat (frequency, duty, timeout flag) yields exactly one result
// beat, in order, and a new beat can enter every cycle while the output is
// not stalled. The resistance quotient 10800000/(duty-500) is computed by a
// restoring divider spread over four stages of four bits each, with one
// classify stage in front and one output register behind. Each stage holds
// its beat while the next one is full, so a stalled output only blocks input
// once all six stages are occupied. The frequency tolerance register resets
// to 200 centihertz and may only be written while no beat is in flight.
`timescale 1ns / 1ps

module imd_pwm_condition_decoder_core
	import imd_pwm_cd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr_en,
	input  logic [8:0] cfg_wr_data,
	input  logic       in_valid,
	output logic       in_ready,
	input  in_beat_t   in_data,
	output logic       out_valid,
	input  logic       out_ready,
	output out_beat_t  out_data
);

	// Half width of every frequency window
	logic [8:0] tol_q;

	logic       div_valid [NUM_DIV_STAGES+1];
	logic       div_ready [NUM_DIV_STAGES+1];
	div_state_t div_data  [NUM_DIV_STAGES+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= TOL_RESET;
		end else if (cfg_wr_en) begin
			tol_q <= cfg_wr_data;
		end
	end

	// Stage 1: pick the condition, check the duty, seed the divider
	imd_pwm_cd_classify u_classify (
		.clk      (clk),
		.arst_n   (arst_n),
		.tol      (tol_q),
		.up_valid (in_valid),
		.up_ready (in_ready),
		.up_data  (in_data),
		.dn_valid (div_valid[0]),
		.dn_ready (div_ready[0]),
		.dn_data  (div_data[0])
	);

	// Stages 2 to 5: four quotient bits each, high bits first
	for (genvar g = 0; g < NUM_DIV_STAGES; g++) begin : g_div
		imd_pwm_cd_div_stage u_div (
			.clk      (clk),
			.arst_n   (arst_n),
			.up_valid (div_valid[g]),
			.up_ready (div_ready[g]),
			.up_data  (div_data[g]),
			.dn_valid (div_valid[g+1]),
			.dn_ready (div_ready[g+1]),
			.dn_data  (div_data[g+1])
		);
	end

	// Stage 6: offset, clamp and hold the result beat
	imd_pwm_cd_finish u_finish (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (div_valid[NUM_DIV_STAGES]),
		.up_ready (div_ready[NUM_DIV_STAGES]),
		.up_data  (div_data[NUM_DIV_STAGES]),
		.dn_valid (out_valid),
		.dn_ready (out_ready),
		.dn_data  (out_data)
	);

endmodule

FILE: rtl/core/imd_pwm_cd_checker.sv
// ----------------------------------------------------------------------------
// IMD PWM condition decoder checker
// Port-level checks on result beats, bound to the decoder core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "imd_pwm_condition_decoder_core_defines.svh"

module imd_pwm_cd_checker
	import imd_pwm_cd_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	input logic      out_valid,
	input logic      out_ready,
	input out_beat_t out_data
);

	logic res_nonzero;
	logic res_allowed;
	logic sst_reported;
	logic sst_allowed;
	logic is_short;

	assign res_nonzero  = out_data.insulation_kohms != 16'd0;
	assign res_allowed  = out_data.duty_valid &&
		((out_data.condition_code == COND_NORMAL) ||
		(out_data.condition_code == COND_UNDERVOLT));
	assign sst_reported = out_data.start_status != SST_NONE;
	assign sst_allowed  = out_data.duty_valid && (out_data.condition_code == COND_SST);
	assign is_short     = out_data.condition_code == COND_SHORT;

	`IMD_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_data))
	`IMD_ASSERT_IMPL(a_res_range, clk, arst_n, out_valid, out_data.insulation_kohms <= RES_MAX)
	`IMD_ASSERT_IMPL(a_res_cond, clk, arst_n, out_valid && res_nonzero, res_allowed)
	`IMD_ASSERT_IMPL(a_sst_cond, clk, arst_n, out_valid && sst_reported, sst_allowed)
	`IMD_ASSERT_IMPL(a_short_valid, clk, arst_n, out_valid && is_short, out_data.duty_valid)

endmodule

bind imd_pwm_condition_decoder_core imd_pwm_cd_checker u_imd_pwm_cd_checker (.*);

FILE: tb/tb_imd_pwm_condition_decoder_core.sv
// ----------------------------------------------------------------------------
// IMD PWM condition decoder core testbench
// Streams PWM measurements through the decoder under random backpressure and
// checks every decoded result against a cycle-free predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_imd_pwm_condition_decoder_core;
	import imd_pwm_cd_pkg::*;

	// Decoder thresholds, kept separate from the package so a wrong package
	// constant shows up as a mismatch instead of being copied into the check.
	localparam int unsigned WIN_STEP_CHZ   = 1000;
	localparam int unsigned WIN_COUNT      = 6;
	localparam int unsigned DUTY_MIN_OK    = 500;
	localparam int unsigned DUTY_MAX_OK    = 9500;
	localparam int unsigned SST_PASS_TOP   = 1000;
	localparam int unsigned SST_BAD_BASE   = 9000;
	localparam int unsigned FAULT_DUTY_MIN = 4750;
	localparam int unsigned FAULT_DUTY_MAX = 5250;
	localparam int unsigned KOHM_NUMER     = 10800000;
	localparam int unsigned KOHM_OFFSET    = 1200;
	localparam int unsigned KOHM_CEILING   = 50000;
	localparam int unsigned TOL_AT_RESET   = 200;

	localparam int unsigned LONG_HOLD      = 80;
	// Longest legal quiet stretch is the long output hold plus one idle burst;
	// take that many times over.
	localparam int unsigned QUIET_LIMIT    = 2000;
	localparam int unsigned DRAIN_CYCLES   = 12;
	localparam int unsigned REPORT_MAX     = 10;
	localparam int unsigned NUM_PHASES     = 8;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cfg_wr_en = 1'b0;
	logic [8:0] cfg_wr_data = '0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	in_beat_t   in_data = '0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	out_beat_t  out_data;

	// Measurements waiting for the driver, and decoded results still owed.
	in_beat_t    pending_measurements[$];
	out_beat_t   expected_results[$];

	int unsigned tol_setting = TOL_AT_RESET;
	int unsigned measurements_queued = 0;
	int unsigned measurements_taken = 0;
	int unsigned results_checked = 0;
	int unsigned error_count = 0;
	int unsigned tol_settings_used = 1;
	int unsigned cond_hits[7] = '{default: 0};

	// Idle odds: one idle burst per this many cycles on average, 0 means none.
	int unsigned in_idle_odds = 0;
	int unsigned out_idle_odds = 0;
	int unsigned in_idle_left = 0;
	int unsigned out_idle_left = 0;
	int unsigned hold_requests = 0;
	int unsigned holds_served = 0;
	int unsigned quiet_cycles = 0;
	logic        in_beat_taken = 1'b0;

	imd_pwm_condition_decoder_core DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.in_data     (in_data),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_data    (out_data)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// Decode one measurement the way the block should: pick the lowest
	// matching frequency window, then qualify the duty cycle for it.
	function automatic out_beat_t decode_measurement(in_beat_t m, int unsigned tol);
		out_beat_t   r;
		cond_t       c;
		sst_t        s;
		int unsigned f, d, lo, hi, nom, q, kohms;
		logic        ok;
		r = '0;
		c = COND_INVALID;
		s = SST_NONE;
		ok = 1'b0;
		kohms = 0;
		f = 32'(m.frequency_centihz);
		d = 32'(m.duty_centipercent);
		if (m.pwm_timed_out) begin
			c = COND_SHORT;
		end else begin
			for (int n = WIN_COUNT - 1; n >= 0; n--) begin
				nom = n * WIN_STEP_CHZ;
				lo = (nom > tol) ? nom - tol : 0;
				hi = nom + tol;
				// Walk downward so the lowest window wins where windows overlap
				if (f >= lo && f <= hi) c = cond_t'(n);
			end
		end
		case (c)
			COND_SHORT: begin
				ok = 1'b1;
			end
			COND_NORMAL, COND_UNDERVOLT: begin
				if (d >= DUTY_MIN_OK && d <= DUTY_MAX_OK) begin
					ok = 1'b1;
					if (d == DUTY_MIN_OK) begin
						kohms = KOHM_CEILING;
					end else begin
						q = KOHM_NUMER / (d - DUTY_MIN_OK);
						kohms = (q > KOHM_OFFSET) ? q - KOHM_OFFSET : 0;
						if (kohms > KOHM_CEILING) kohms = KOHM_CEILING;
					end
				end
			end
			COND_SST: begin
				if (d >= DUTY_MIN_OK && d <= SST_PASS_TOP) begin
					ok = 1'b1;
					s = SST_PASS;
				end else if (d >= SST_BAD_BASE && d <= DUTY_MAX_OK) begin
					ok = 1'b1;
					s = SST_BAD;
				end
			end
			COND_DEV_ERR, COND_GND_FAULT: begin
				ok = (d >= FAULT_DUTY_MIN && d <= FAULT_DUTY_MAX);
			end
			default: begin
				ok = 1'b0;
			end
		endcase
		r.condition_code = c;
		r.duty_valid = ok;
		r.insulation_kohms = kohms[15:0];
		r.start_status = s;
		return r;
	endfunction

	// Mostly frequencies in or just outside a window and duties around the
	// decision edges; the rest is raw noise, partly over the full field widths.
	function automatic in_beat_t random_measurement(int unsigned tol);
		in_beat_t    m;
		int unsigned pick, nom, off, edge_duty;
		int          f;
		m = '0;
		m.pwm_timed_out = ($urandom_range(0, 9) == 0);
		pick = $urandom_range(0, 99);
		if (pick < 70) begin
			nom = WIN_STEP_CHZ * $urandom_range(0, WIN_COUNT - 1);
			off = $urandom_range(0, tol + 15);
			f = $urandom_range(0, 1) ? int'(nom + off) : int'(nom) - int'(off);
			if (f < 0) f = 0;
			m.frequency_centihz = f[15:0];
		end else if (pick < 85) begin
			m.frequency_centihz = 16'($urandom_range(0, 65535));
		end else begin
			m.frequency_centihz = 16'($urandom_range(0, 6000));
		end
		pick = $urandom_range(0, 99);
		if (pick < 35) begin
			m.duty_centipercent = 14'($urandom_range(DUTY_MIN_OK, DUTY_MAX_OK));
		end else if (pick < 55) begin
			case ($urandom_range(0, 6))
				0: edge_duty = DUTY_MIN_OK;
				1: edge_duty = 710;
				2: edge_duty = SST_PASS_TOP;
				3: edge_duty = FAULT_DUTY_MIN;
				4: edge_duty = FAULT_DUTY_MAX;
				5: edge_duty = SST_BAD_BASE;
				default: edge_duty = DUTY_MAX_OK;
			endcase
			m.duty_centipercent = 14'(edge_duty + $urandom_range(0, 4) - 2);
		end else if (pick < 70) begin
			m.duty_centipercent = $urandom_range(0, 1) ?
				14'($urandom_range(DUTY_MIN_OK, SST_PASS_TOP)) :
				14'($urandom_range(SST_BAD_BASE, DUTY_MAX_OK));
		end else if (pick < 80) begin
			m.duty_centipercent = 14'($urandom_range(0, 16383));
		end else begin
			m.duty_centipercent = 14'($urandom_range(0, 10000));
		end
		return m;
	endfunction

	task automatic queue_measurement(int unsigned f, int unsigned d, logic t);
		in_beat_t m;
		m.frequency_centihz = f[15:0];
		m.duty_centipercent = d[13:0];
		m.pwm_timed_out = t;
		pending_measurements.push_back(m);
		measurements_queued++;
	endtask

	// Return at a falling edge once every queued measurement went in and
	// every result came back; the pipeline is then empty.
	task automatic wait_drained();
		@(negedge clk);
		while (measurements_taken != measurements_queued || expected_results.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_tolerance(int unsigned tol);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= tol[8:0];
		tol_setting = tol;
		tol_settings_used++;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// Input driver: hold a beat until it is taken, otherwise idle in bursts
	// or present the next pending measurement.
	always @(negedge clk) begin : driver
		if (arst_n) begin
			if (in_valid && !in_beat_taken) begin
				// hold the offered beat
			end else begin
				if (in_idle_left > 0) begin
					in_idle_left--;
					in_valid <= 1'b0;
				end else if (in_idle_odds != 0 && pending_measurements.size() != 0 &&
						$urandom_range(0, in_idle_odds - 1) == 0) begin
					in_idle_left = $urandom_range(1, 12) - 1;
					in_valid <= 1'b0;
				end else if (pending_measurements.size() != 0) begin
					in_data <= pending_measurements.pop_front();
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Output ready: serve a requested long hold first, then random bursts.
	always @(negedge clk) begin : receiver
		if (arst_n) begin
			if (hold_requests != holds_served) begin
				holds_served++;
				out_idle_left = LONG_HOLD - 1;
				out_ready <= 1'b0;
			end else if (out_idle_left > 0) begin
				out_idle_left--;
				out_ready <= 1'b0;
			end else if (out_idle_odds != 0 && $urandom_range(0, out_idle_odds - 1) == 0) begin
				out_idle_left = $urandom_range(1, 12) - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Monitor: predict on every accepted input beat, check every accepted
	// output beat against the oldest prediction.
	always @(posedge clk) begin : monitor
		out_beat_t want;
		if (arst_n) begin
			in_beat_taken <= in_valid && in_ready;
			if (in_valid && in_ready) begin
				want = decode_measurement(in_data, tol_setting);
				expected_results.push_back(want);
				cond_hits[want.condition_code]++;
				measurements_taken++;
			end
			if (out_valid && out_ready) begin
				results_checked++;
				if (expected_results.size() == 0) begin
					error_count++;
					if (error_count <= REPORT_MAX)
						$display("%0t: result beat with nothing pending: %0d %0d %0d %0d",
							$realtime, out_data.condition_code, out_data.duty_valid,
							out_data.insulation_kohms, out_data.start_status);
				end else begin
					want = expected_results.pop_front();
					if (out_data.condition_code !== want.condition_code ||
							out_data.duty_valid !== want.duty_valid ||
							out_data.insulation_kohms !== want.insulation_kohms ||
							out_data.start_status !== want.start_status) begin
						error_count++;
						if (error_count <= REPORT_MAX)
							$display({"%0t: mismatch (expected/actual): cond %0d/%0d ",
								"valid %0d/%0d kohms %0d/%0d sst %0d/%0d"},
								$realtime, want.condition_code, out_data.condition_code,
								want.duty_valid, out_data.duty_valid,
								want.insulation_kohms, out_data.insulation_kohms,
								want.start_status, out_data.start_status);
					end
				end
			end
		end
	end

	// Watchdog: end the run if no beat moves on either side for too long.
	always @(posedge clk) begin : watchdog
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
				if (quiet_cycles >= QUIET_LIMIT) begin
					$display("%0t: no beat moved for %0d cycles", $realtime, QUIET_LIMIT);
					$display("TB_ERROR");
					$finish;
				end
			end
		end
	end

	initial begin : stimulus
		int unsigned phase_tol[NUM_PHASES];
		int unsigned phase_items[NUM_PHASES];
		int unsigned phase_in_odds[NUM_PHASES];
		int unsigned phase_out_odds[NUM_PHASES];
		phase_tol = '{200, 0, 499, 511, 500, 0, 1, 200};
		phase_items = '{160, 170, 190, 170, 170, 190, 170, 240};
		phase_in_odds = '{5, 3, 8, 4, 6, 0, 2, 0};
		phase_out_odds = '{6, 4, 3, 8, 5, 0, 3, 0};
		phase_tol[5] = $urandom_range(2, 498);

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		for (int p = 0; p < NUM_PHASES; p++) begin
			// Change the tolerance only with the pipeline empty; this also
			// makes the sender wait for every outstanding result.
			if (p > 0) begin
				wait_drained();
				write_tolerance(phase_tol[p]);
			end
			in_idle_odds = phase_in_odds[p];
			out_idle_odds = phase_out_odds[p];

			if (p == 0) begin
				// Timeout overrides everything, with all other bits set
				queue_measurement(16'hFFFF, 14'h3FFF, 1'b1);
				// 0 Hz window and its upper edge, then the gap above it
				queue_measurement(0, 0, 1'b0);
				queue_measurement(200, 10000, 1'b0);
				queue_measurement(201, 500, 1'b0);
				// 10 Hz window edges and the resistance formula corners
				queue_measurement(799, 500, 1'b0);
				queue_measurement(800, 500, 1'b0);
				queue_measurement(1000, 499, 1'b0);
				queue_measurement(1000, 501, 1'b0);
				queue_measurement(1000, 710, 1'b0);
				queue_measurement(1000, 711, 1'b0);
				queue_measurement(1200, 9500, 1'b0);
				queue_measurement(1201, 9500, 1'b0);
				queue_measurement(1100, 9501, 1'b0);
				// Undervoltage
				queue_measurement(2000, 5000, 1'b0);
				// Speed start good and bad bands with their edges
				queue_measurement(3000, 500, 1'b0);
				queue_measurement(3000, 1000, 1'b0);
				queue_measurement(3000, 1001, 1'b0);
				queue_measurement(3000, 8999, 1'b0);
				queue_measurement(3000, 9000, 1'b0);
				queue_measurement(3200, 9500, 1'b0);
				// Device error and ground fault duty windows
				queue_measurement(4000, 4750, 1'b0);
				queue_measurement(3800, 4749, 1'b0);
				queue_measurement(5000, 5250, 1'b0);
				queue_measurement(5200, 5251, 1'b0);
				// Above the last window, and duty past 100 percent
				queue_measurement(5201, 5000, 1'b0);
				queue_measurement(16'hFFFF, 14'h3FFF, 1'b0);
				queue_measurement(1000, 16383, 1'b0);
			end

			for (int k = 0; k < phase_items[p]; k++)
				pending_measurements.push_back(random_measurement(tol_setting));
			measurements_queued += phase_items[p];

			// Stall the output long enough to back the pipeline up into the
			// input while the driver keeps offering beats.
			if (p == 0 || p == 2) hold_requests++;
		end

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Checked %0d results from %0d measurements over %0d tolerance settings.",
			results_checked, measurements_taken, tol_settings_used);
		$display({"Conditions: short %0d, normal %0d, undervolt %0d, speed start %0d, ",
			"dev err %0d, gnd fault %0d, invalid %0d; %0d errors."},
			cond_hits[COND_SHORT], cond_hits[COND_NORMAL], cond_hits[COND_UNDERVOLT],
			cond_hits[COND_SST], cond_hits[COND_DEV_ERR], cond_hits[COND_GND_FAULT],
			cond_hits[COND_INVALID], error_count);
		if (error_count == 0 && expected_results.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
